// ----- src/nsp_pkg.sv -----
// Shared constants and types for the nearest segment pick block.
// No dependencies; used by nsp_dist and nearest_segment_pick_core.
package nsp_pkg;

  // Default structural sizes.
  localparam int unsigned MAX_SEGMENTS_DEF = 1024;
  localparam int unsigned COORD_BITS_DEF   = 20;
  // Coordinates wider than this are cut to this width and sign-extended from its top bit.
  localparam int unsigned EFF_BITS_MAX     = 29;

  // Fixed field widths.
  localparam int unsigned COUNT_W    = 11;
  localparam int unsigned TOL_W      = 16;
  localparam int unsigned INDEX_W    = 10;
  localparam int unsigned CFG_ADDR_W = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [TOL_W-1:0] TOL_RESET = 16'd160;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_SEGMENT_COUNT  = 8'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PICK_TOLERANCE = 8'd1;

  // Input action codes.
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_CLICK = 1'b1;

  // Status of one distance evaluation.
  typedef struct packed {
    logic done;
    logic valid;
  } dist_stat_t;

endpackage

// ----- src/nsp_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Self-contained; used by nsp_dist for the interior distance case.
module nsp_div #(
  parameter int unsigned PW = 42
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            go_i,
  input  logic [2*PW-1:0] dividend_i,
  input  logic [PW-1:0]   divisor_i,
  output logic            done_o,
  output logic [PW-1:0]   quot_o
);

  localparam int unsigned CNT_W = $clog2(PW + 1);

  logic              run_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [PW-1:0]     rem_q;
  logic [PW-1:0]     low_q;
  logic [PW-1:0]     div_q;
  logic [PW-1:0]     quot_q;
  logic [PW:0]       trial;
  logic [PW:0]       diff;
  logic              ge;
  logic [PW-1:0]     rem_next;

  // Trial subtraction of the divisor from the shifted remainder.
  always_comb begin
    trial    = {rem_q, low_q[PW-1]};
    diff     = trial - {1'b0, div_q};
    ge       = (trial >= {1'b0, div_q});
    rem_next = ge ? diff[PW-1:0] : trial[PW-1:0];
  end

  // The upper half of the dividend is always below the divisor, so it seeds the remainder.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      low_q  <= '0;
      div_q  <= '0;
      quot_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        rem_q  <= dividend_i[2*PW-1:PW];
        low_q  <= dividend_i[PW-1:0];
        div_q  <= divisor_i;
        cnt_q  <= CNT_W'(PW);
        run_q  <= 1'b1;
      end else if (run_q) begin
        rem_q  <= rem_next;
        low_q  <= low_q << 1;
        quot_q <= {quot_q[PW-2:0], ge};
        cnt_q  <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ----- src/nsp_dist.sv -----
// Point to segment squared distance unit with one shared registered multiplier.
// Depends on nsp_pkg and nsp_div.
module nsp_dist #(
  parameter int unsigned EB = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                go_i,
  input  logic [EB-1:0]       ax_i,
  input  logic [EB-1:0]       ay_i,
  input  logic [EB-1:0]       bx_i,
  input  logic [EB-1:0]       by_i,
  input  logic [EB-1:0]       px_i,
  input  logic [EB-1:0]       py_i,
  output nsp_pkg::dist_stat_t stat_o,
  output logic [2*(EB+1)-1:0] dist_o
);

  localparam int unsigned DW  = EB + 1;
  localparam int unsigned PW  = 2 * DW;
  localparam int unsigned MW  = DW + 1;
  localparam int unsigned PRW = 2 * MW;
  localparam int unsigned SQW = 2 * PW;

  // Multiplier step codes.
  localparam logic [3:0] ST_DOT_X  = 4'd0;
  localparam logic [3:0] ST_DOT_Y  = 4'd1;
  localparam logic [3:0] ST_LEN_X  = 4'd2;
  localparam logic [3:0] ST_LEN_Y  = 4'd3;
  localparam logic [3:0] ST_CR_A   = 4'd4;
  localparam logic [3:0] ST_CR_B   = 4'd5;
  localparam logic [3:0] ST_AP_X   = 4'd6;
  localparam logic [3:0] ST_AP_Y   = 4'd7;
  localparam logic [3:0] ST_BP_X   = 4'd8;
  localparam logic [3:0] ST_BP_Y   = 4'd9;
  localparam logic [3:0] ST_SQ_HH  = 4'd10;
  localparam logic [3:0] ST_SQ_HL  = 4'd11;
  localparam logic [3:0] ST_SQ_LL  = 4'd12;

  typedef enum logic [7:0] {
    D_IDLE  = 8'b0000_0001,
    D_MUL   = 8'b0000_0010,
    D_MWAIT = 8'b0000_0100,
    D_DEC   = 8'b0000_1000,
    D_SQ    = 8'b0001_0000,
    D_SWAIT = 8'b0010_0000,
    D_DIVGO = 8'b0100_0000,
    D_DIV   = 8'b1000_0000
  } dstate_e;

  dstate_e              state_q, state_d;
  logic [3:0]           step_q;
  logic [3:0]           tag_q;
  logic                 pv_q;
  logic signed [DW-1:0] abx_q, aby_q, apx_q, apy_q, bpx_q, bpy_q;
  logic signed [MW-1:0] ma, mb;
  logic signed [PRW-1:0] p_q;
  logic signed [PW:0]   pn;
  logic signed [PW:0]   dot_q, len_q, cr_q, ap_q, bp_q;
  logic signed [PW:0]   cr_abs;
  logic [PW-1:0]        c_q;
  logic [SQW-1:0]       sq_q;
  logic [SQW-1:0]       pext;
  nsp_pkg::dist_stat_t  stat_q;
  logic [PW-1:0]        dist_q;
  logic                 div_go;
  logic                 div_done;
  logic [PW-1:0]        div_quot;
  logic signed [DW-1:0] axs, ays, bxs, bys, pxs, pys;

  // Sign extension of the stored coordinates.
  always_comb begin
    axs = $signed({ax_i[EB-1], ax_i});
    ays = $signed({ay_i[EB-1], ay_i});
    bxs = $signed({bx_i[EB-1], bx_i});
    bys = $signed({by_i[EB-1], by_i});
    pxs = $signed({px_i[EB-1], px_i});
    pys = $signed({py_i[EB-1], py_i});
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (step_q)
      ST_DOT_X: begin ma = {abx_q[DW-1], abx_q}; mb = {apx_q[DW-1], apx_q}; end
      ST_DOT_Y: begin ma = {aby_q[DW-1], aby_q}; mb = {apy_q[DW-1], apy_q}; end
      ST_LEN_X: begin ma = {abx_q[DW-1], abx_q}; mb = {abx_q[DW-1], abx_q}; end
      ST_LEN_Y: begin ma = {aby_q[DW-1], aby_q}; mb = {aby_q[DW-1], aby_q}; end
      ST_CR_A:  begin ma = {abx_q[DW-1], abx_q}; mb = {apy_q[DW-1], apy_q}; end
      ST_CR_B:  begin ma = {aby_q[DW-1], aby_q}; mb = {apx_q[DW-1], apx_q}; end
      ST_AP_X:  begin ma = {apx_q[DW-1], apx_q}; mb = {apx_q[DW-1], apx_q}; end
      ST_AP_Y:  begin ma = {apy_q[DW-1], apy_q}; mb = {apy_q[DW-1], apy_q}; end
      ST_BP_X:  begin ma = {bpx_q[DW-1], bpx_q}; mb = {bpx_q[DW-1], bpx_q}; end
      ST_BP_Y:  begin ma = {bpy_q[DW-1], bpy_q}; mb = {bpy_q[DW-1], bpy_q}; end
      ST_SQ_HH: begin ma = {1'b0, c_q[PW-1:DW]}; mb = {1'b0, c_q[PW-1:DW]}; end
      ST_SQ_HL: begin ma = {1'b0, c_q[PW-1:DW]}; mb = {1'b0, c_q[DW-1:0]}; end
      ST_SQ_LL: begin ma = {1'b0, c_q[DW-1:0]};  mb = {1'b0, c_q[DW-1:0]};  end
      default:  begin ma = '0; mb = '0; end
    endcase
  end

  assign pn     = p_q[PW:0];
  assign pext   = SQW'(p_q[PW-1:0]);
  assign cr_abs = (cr_q < 0) ? -cr_q : cr_q;

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      D_IDLE:  if (go_i) state_d = D_MUL;
      D_MUL:   if (step_q == ST_BP_Y) state_d = D_MWAIT;
      D_MWAIT: state_d = D_DEC;
      D_DEC: begin
        if (len_q == 0 || dot_q < 0 || dot_q > len_q) begin
          state_d = D_IDLE;
        end else begin
          state_d = D_SQ;
        end
      end
      D_SQ:    if (step_q == ST_SQ_LL) state_d = D_SWAIT;
      D_SWAIT: state_d = D_DIVGO;
      D_DIVGO: state_d = D_DIV;
      D_DIV:   if (div_done) state_d = D_IDLE;
      default: state_d = D_IDLE;
    endcase
  end

  assign div_go = (state_q == D_DIVGO);

  // Sequencer, multiplier pipeline and accumulators.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      step_q  <= ST_DOT_X;
      tag_q   <= ST_DOT_X;
      pv_q    <= 1'b0;
      stat_q  <= '0;
      p_q     <= '0;
      abx_q   <= '0; aby_q <= '0; apx_q <= '0;
      apy_q   <= '0; bpx_q <= '0; bpy_q <= '0;
      dot_q   <= '0; len_q <= '0; cr_q <= '0; ap_q <= '0; bp_q <= '0;
      c_q     <= '0;
      sq_q    <= '0;
      dist_q  <= '0;
    end else begin
      state_q <= state_d;
      stat_q  <= '0;
      p_q     <= ma * mb;
      tag_q   <= step_q;
      pv_q    <= (state_q == D_MUL) || (state_q == D_SQ);

      // Capture the difference vectors for a new segment.
      if (state_q == D_IDLE && go_i) begin
        abx_q  <= bxs - axs;
        aby_q  <= bys - ays;
        apx_q  <= pxs - axs;
        apy_q  <= pys - ays;
        bpx_q  <= pxs - bxs;
        bpy_q  <= pys - bys;
        step_q <= ST_DOT_X;
      end else if (state_q == D_MUL || state_q == D_SQ) begin
        step_q <= step_q + 4'd1;
      end

      // Fold each product into its sum.
      if (pv_q) begin
        case (tag_q)
          ST_DOT_X: dot_q <= pn;
          ST_DOT_Y: dot_q <= dot_q + pn;
          ST_LEN_X: len_q <= pn;
          ST_LEN_Y: len_q <= len_q + pn;
          ST_CR_A:  cr_q  <= pn;
          ST_CR_B:  cr_q  <= cr_q - pn;
          ST_AP_X:  ap_q  <= pn;
          ST_AP_Y:  ap_q  <= ap_q + pn;
          ST_BP_X:  bp_q  <= pn;
          ST_BP_Y:  bp_q  <= bp_q + pn;
          ST_SQ_HH: sq_q  <= pext << (2 * DW);
          ST_SQ_HL: sq_q  <= sq_q + (pext << (DW + 1));
          ST_SQ_LL: sq_q  <= sq_q + pext;
          default:  ;
        endcase
      end

      // Reject a zero-length segment, pick the clamped end or start the interior computation.
      if (state_q == D_DEC) begin
        if (len_q == 0) begin
          stat_q <= '{done: 1'b1, valid: 1'b0};
        end else if (dot_q < 0) begin
          stat_q <= '{done: 1'b1, valid: 1'b1};
          dist_q <= ap_q[PW-1:0];
        end else if (dot_q > len_q) begin
          stat_q <= '{done: 1'b1, valid: 1'b1};
          dist_q <= bp_q[PW-1:0];
        end else begin
          c_q    <= cr_abs[PW-1:0];
          step_q <= ST_SQ_HH;
        end
      end

      if (state_q == D_DIV && div_done) begin
        stat_q <= '{done: 1'b1, valid: 1'b1};
        dist_q <= div_quot;
      end
    end
  end

  nsp_div #(
    .PW(PW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (div_go),
    .dividend_i (sq_q),
    .divisor_i  (len_q[PW-1:0]),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign stat_o = stat_q;
  assign dist_o = dist_q;

endmodule

// ----- src/nearest_segment_pick_core.sv -----
// Nearest segment pick: segment table, active bits, scan control and result register.
// Depends on nsp_pkg and nsp_dist.
// A load writes its table entry and sets its active bit as it is accepted. A click
// scans the segments one after another in the shared distance unit; a segment whose
// projection falls inside it also needs the squaring steps and the divider.
// After reset a clearing pass over every entry zeroes the active bits, busy high.
// The result strobe lasts one cycle; the receiver cannot stall.
module nearest_segment_pick_core #(
  parameter int unsigned MAX_SEGMENTS = nsp_pkg::MAX_SEGMENTS_DEF,
  parameter int unsigned COORD_BITS   = nsp_pkg::COORD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic                           action_i,
  input  logic [nsp_pkg::INDEX_W-1:0]    entry_index_i,
  input  logic [COORD_BITS-1:0]          start_x_i,
  input  logic [COORD_BITS-1:0]          start_y_i,
  input  logic [COORD_BITS-1:0]          end_x_i,
  input  logic [COORD_BITS-1:0]          end_y_i,
  input  logic [COORD_BITS-1:0]          click_x_i,
  input  logic [COORD_BITS-1:0]          click_y_i,
  output logic                           valid_o,
  output logic                           hit_o,
  output logic [nsp_pkg::INDEX_W-1:0]    hit_index_o,
  output logic                           was_active_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [nsp_pkg::CFG_ADDR_W-1:0] cfg_index_i,
  input  logic [nsp_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned EB = (COORD_BITS > nsp_pkg::EFF_BITS_MAX) ?
                               nsp_pkg::EFF_BITS_MAX : COORD_BITS;
  localparam int unsigned AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned NW = AW + 1;
  localparam int unsigned SW = 4 * EB;
  localparam int unsigned PW = 2 * (EB + 1);
  localparam int unsigned BW = (PW > 32) ? PW : 32;

  typedef enum logic [6:0] {
    T_CLR   = 7'b000_0001,
    T_IDLE  = 7'b000_0010,
    T_RD    = 7'b000_0100,
    T_DGO   = 7'b000_1000,
    T_DWAIT = 7'b001_0000,
    T_ACT   = 7'b010_0000,
    T_OUT   = 7'b100_0000
  } tstate_e;

  tstate_e                       state_q;
  logic [nsp_pkg::COUNT_W-1:0]   count_q;
  logic [nsp_pkg::TOL_W-1:0]     tol_q;
  logic [AW-1:0]                 clr_q;
  logic [NW-1:0]                 k_q;
  logic [NW-1:0]                 n_q;
  logic [NW-1:0]                 k_next;
  logic [BW-1:0]                 best_q;
  logic                          found_q;
  logic [AW-1:0]                 idx_q;
  logic [EB-1:0]                 px_q, py_q;
  logic                          valid_q, hit_q, was_q;
  logic [nsp_pkg::INDEX_W-1:0]   hidx_q;

  logic [SW-1:0]                 seg_mem [MAX_SEGMENTS];
  logic [SW-1:0]                 seg_rdata_q;
  logic                          act_mem [MAX_SEGMENTS];
  logic                          act_rdata_q;

  logic                          accept;
  logic                          load_ok;
  logic [31:0]                   entry32;
  logic [31:0]                   n32;
  logic [31:0]                   tol_sq;
  logic [31:0]                   idx32;
  logic [AW-1:0]                 load_addr;
  logic                          act_we;
  logic [AW-1:0]                 act_waddr;
  logic                          act_wdata;
  logic                          better;
  nsp_pkg::dist_stat_t           dstat;
  logic [PW-1:0]                 seg_dist;

  assign accept      = start_i && !busy_o;
  assign busy_o      = (state_q != T_IDLE);
  assign cfg_ready_o = 1'b1;

  // Address and limit arithmetic.
  always_comb begin
    entry32   = {{(32 - nsp_pkg::INDEX_W){1'b0}}, entry_index_i};
    load_ok   = (entry32 < MAX_SEGMENTS);
    load_addr = entry32[AW-1:0];
    n32       = ({21'b0, count_q} > MAX_SEGMENTS) ? MAX_SEGMENTS : {21'b0, count_q};
    tol_sq    = {16'b0, tol_q} * {16'b0, tol_q};
    idx32     = '0;
    idx32[AW-1:0] = idx_q;
    k_next    = k_q + 1'b1;
    better    = dstat.valid && ({{(BW - PW){1'b0}}, seg_dist} < best_q);
  end

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      tol_q   <= nsp_pkg::TOL_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        nsp_pkg::REG_SEGMENT_COUNT:  count_q <= cfg_data_i[nsp_pkg::COUNT_W-1:0];
        nsp_pkg::REG_PICK_TOLERANCE: tol_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Segment store: written by loads, read one entry per scan step.
  always_ff @(posedge clk_i) begin
    if (accept && action_i == nsp_pkg::ACT_LOAD && load_ok) begin
      seg_mem[load_addr] <= {start_x_i[EB-1:0], start_y_i[EB-1:0],
                             end_x_i[EB-1:0], end_y_i[EB-1:0]};
    end
    seg_rdata_q <= seg_mem[k_q[AW-1:0]];
  end

  // Active bit write port: clearing pass, load set, or clear of the picked entry.
  always_comb begin
    act_we    = 1'b0;
    act_waddr = idx_q;
    act_wdata = 1'b0;
    if (state_q == T_CLR) begin
      act_we    = 1'b1;
      act_waddr = clr_q;
    end else if (accept && action_i == nsp_pkg::ACT_LOAD && load_ok) begin
      act_we    = 1'b1;
      act_waddr = load_addr;
      act_wdata = 1'b1;
    end else if (state_q == T_OUT && found_q) begin
      act_we    = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (act_we) begin
      act_mem[act_waddr] <= act_wdata;
    end
    act_rdata_q <= act_mem[idx_q];
  end

  // Scan control and best candidate tracking.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_CLR;
      clr_q   <= '0;
      k_q     <= '0;
      n_q     <= '0;
      best_q  <= '0;
      found_q <= 1'b0;
      idx_q   <= '0;
      px_q    <= '0;
      py_q    <= '0;
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
      hidx_q  <= '0;
      was_q   <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        T_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(MAX_SEGMENTS - 1)) begin
            state_q <= T_IDLE;
          end
        end
        T_IDLE: begin
          if (accept && action_i == nsp_pkg::ACT_CLICK) begin
            px_q    <= click_x_i[EB-1:0];
            py_q    <= click_y_i[EB-1:0];
            n_q     <= n32[NW-1:0];
            k_q     <= '0;
            best_q  <= BW'(tol_sq);
            found_q <= 1'b0;
            idx_q   <= '0;
            state_q <= (n32 == 32'd0) ? T_ACT : T_RD;
          end
        end
        T_RD:  state_q <= T_DGO;
        T_DGO: state_q <= T_DWAIT;
        T_DWAIT: begin
          if (dstat.done) begin
            if (better) begin
              best_q  <= {{(BW - PW){1'b0}}, seg_dist};
              found_q <= 1'b1;
              idx_q   <= k_q[AW-1:0];
            end
            k_q     <= k_next;
            state_q <= (k_next == n_q) ? T_ACT : T_RD;
          end
        end
        T_ACT: state_q <= T_OUT;
        T_OUT: begin
          valid_q <= 1'b1;
          hit_q   <= found_q;
          hidx_q  <= found_q ? idx32[nsp_pkg::INDEX_W-1:0] : '0;
          was_q   <= found_q && act_rdata_q;
          state_q <= T_IDLE;
        end
        default: state_q <= T_IDLE;
      endcase
    end
  end

  nsp_dist #(
    .EB(EB)
  ) u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (state_q == T_DGO),
    .ax_i   (seg_rdata_q[4*EB-1:3*EB]),
    .ay_i   (seg_rdata_q[3*EB-1:2*EB]),
    .bx_i   (seg_rdata_q[2*EB-1:EB]),
    .by_i   (seg_rdata_q[EB-1:0]),
    .px_i   (px_q),
    .py_i   (py_q),
    .stat_o (dstat),
    .dist_o (seg_dist)
  );

  assign valid_o      = valid_q;
  assign hit_o        = hit_q;
  assign hit_index_o  = hidx_q;
  assign was_active_o = was_q;

  // A result appears only in the cycle after the result state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(state_q == T_OUT))
    else $error("result strobe without finished scan");

  // A miss reports index zero and no prior active bit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !hit_o) |-> (hit_index_o == '0 && !was_active_o))
    else $error("miss result carries index or active bit");

  // The distance unit only reports while the scan waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dstat.done |-> (state_q == T_DWAIT))
    else $error("distance result outside the wait state");

  // The scan never runs past the segment count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == T_RD) |-> (k_q < n_q))
    else $error("scan index beyond segment count");

endmodule
